// File: rtl/core/tli_pkg.sv
// Package for the tape language interpreter core.
// Holds operation, command and fault codes, default sizes and the result word layout.
// Used by the core and the port checker.
package tli_pkg;

	localparam int TAPE_CELLS_DEF    = 32768;
	localparam int PROGRAM_WORDS_DEF = 4096;
	localparam int LOOP_DEPTH_DEF    = 64;

	localparam int LEN_W       = 13;
	localparam int LOAD_ADDR_W = 12;
	localparam int CMD_W       = 3;
	localparam int OP_W        = 2;
	localparam int FAULT_W     = 2;

	localparam int S_TDATA_W = 24;
	localparam int S_TUSER_W = 3;
	localparam int M_TDATA_W = 16;

	localparam int M_TAKEN_BIT = 8;
	localparam int M_STALL_BIT = 9;
	localparam int M_HALT_BIT  = 10;
	localparam int M_FAULT_LSB = 11;

	localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
	localparam logic [OP_W-1:0] OP_STEP    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam logic [CMD_W-1:0] CMD_INC   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_DEC   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LEFT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_OUT   = 3'd4;
	localparam logic [CMD_W-1:0] CMD_IN    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd6;
	localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd7;

	localparam logic [FAULT_W-1:0] FAULT_NONE      = 2'd0;
	localparam logic [FAULT_W-1:0] FAULT_OVERFLOW  = 2'd1;
	localparam logic [FAULT_W-1:0] FAULT_UNMATCHED = 2'd2;

endpackage

// File: rtl/core/tli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the tape, program store and loop stack; no dependencies.
module tli_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/core/tape_language_interpreter_core.sv
// Top level of the tape language interpreter core: sequencer, tape, program store, loop stack.
// Depends on tli_pkg and tli_ram.
//
//  Channel  Direction  Word contents (low bit first)
//  s_*      in         tdata: load_address, command, input_byte; tuser: operation, input_valid
//  m_*      out        tdata: out_byte, input_taken, stalled, halted, fault; tuser: out_valid
//  cfg_*    in         program_length, written when cfg_we is high
//
// A load or an unused operation goes from ST_IDLE to ST_REPLY; a step that executes one command goes to ST_EXEC.
// An open bracket on a zero cell scans the program store in ST_SCAN, one word at a time, for its match,
// since the program store has a single read port.
// Reset and every restart run a clearing pass over all TAPE_CELLS tape cells (32768 by default),
// one cell per cycle, during which s_tready is low.
// A new word is taken while a result still waits on m_tready; it finishes once m_* is free.
module tape_language_interpreter_core #(
	parameter int TAPE_CELLS    = tli_pkg::TAPE_CELLS_DEF,
	parameter int PROGRAM_WORDS = tli_pkg::PROGRAM_WORDS_DEF,
	parameter int LOOP_DEPTH    = tli_pkg::LOOP_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tli_pkg::S_TDATA_W-1:0]  s_tdata,  // load_address, command, input_byte
	input  logic [tli_pkg::S_TUSER_W-1:0]  s_tuser,  // operation, input_valid
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [tli_pkg::M_TDATA_W-1:0]  m_tdata,  // out_byte, input_taken, stalled, halted, fault
	output logic                           m_tuser,  // out_valid
	input  logic                           cfg_we,
	input  logic [tli_pkg::LEN_W-1:0]      cfg_wdata
);

	localparam int TAW = $clog2(TAPE_CELLS);
	localparam int PAW = $clog2(PROGRAM_WORDS);
	localparam int PCW = $clog2(PROGRAM_WORDS + 1);
	localparam int SAW = $clog2(LOOP_DEPTH);
	localparam int SDW = $clog2(LOOP_DEPTH + 1);
	localparam int CW  = (tli_pkg::LEN_W > PCW) ? tli_pkg::LEN_W : PCW;
	localparam int AXW = (tli_pkg::LOAD_ADDR_W > PCW) ? tli_pkg::LOAD_ADDR_W : PCW;

	localparam logic [CW-1:0]  PW_LEN    = CW'(PROGRAM_WORDS);
	localparam logic [AXW-1:0] PW_ADDR   = AXW'(PROGRAM_WORDS);
	localparam logic [TAW-1:0] TAPE_MID  = TAW'(TAPE_CELLS / 2);
	localparam logic [TAW-1:0] TAPE_LAST = TAW'(TAPE_CELLS - 1);
	localparam logic [SDW-1:0] STK_FULL  = SDW'(LOOP_DEPTH);
	localparam logic [PCW-1:0] NEST_ONE  = PCW'(1);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_EXEC  = 3'd2;
	localparam logic [2:0] ST_SCAN  = 3'd3;
	localparam logic [2:0] ST_REPLY = 3'd4;

	logic [tli_pkg::OP_W-1:0]        in_op;
	logic [tli_pkg::LOAD_ADDR_W-1:0] in_addr;
	logic [tli_pkg::CMD_W-1:0]       in_cmd;

	logic [2:0]                  state_q, state_d;
	logic [TAW-1:0]              clr_q, clr_d;
	logic                        reply_q, reply_d;
	logic [PCW-1:0]              pc_q, pc_d;
	logic [TAW-1:0]              ptr_q, ptr_d;
	logic [SDW-1:0]              depth_q, depth_d;
	logic                        halt_q, halt_d;
	logic [tli_pkg::FAULT_W-1:0] fault_q, fault_d;
	logic [PCW-1:0]              scan_q, scan_d;
	logic [PCW-1:0]              nest_q, nest_d;
	logic [tli_pkg::LEN_W-1:0]   len_cfg_q;
	logic                        in_valid_q;
	logic [7:0]                  in_byte_q;

	logic                         m_tvalid_q;
	logic [tli_pkg::M_TDATA_W-1:0] m_tdata_q;
	logic                         m_tuser_q;

	logic [CW-1:0]  len_ext;
	logic [PCW-1:0] len_w;
	logic           addr_ok;
	logic           out_free;
	logic [PCW-1:0] pc_inc;
	logic [PCW-1:0] scan_inc;

	logic                        prog_we;
	logic [PAW-1:0]              prog_waddr;
	logic [PAW-1:0]              prog_raddr;
	logic [tli_pkg::CMD_W-1:0]   prog_rdata;
	logic                        tape_we;
	logic [TAW-1:0]              tape_waddr;
	logic [7:0]                  tape_wdata;
	logic [7:0]                  tape_rdata;
	logic                        stk_we;
	logic [SAW-1:0]              stk_raddr;
	logic [PAW-1:0]              stk_top;

	logic       fin;
	logic       r_out_valid;
	logic [7:0] r_out_byte;
	logic       r_taken;
	logic       r_stalled;

	assign in_addr = s_tdata[11:0];
	assign in_cmd  = s_tdata[14:12];
	assign in_op   = s_tuser[1:0];

	assign len_ext  = CW'(len_cfg_q);
	assign len_w    = (len_ext > PW_LEN) ? PW_LEN[PCW-1:0] : len_ext[PCW-1:0];
	assign addr_ok  = AXW'(in_addr) < PW_ADDR;
	assign out_free = !m_tvalid_q || m_tready;
	assign pc_inc   = pc_q + 1'b1;
	assign scan_inc = scan_q + 1'b1;

	assign s_tready   = (state_q == ST_IDLE);
	assign prog_waddr = PAW'(in_addr);
	assign stk_raddr  = SAW'(depth_q - 1'b1);

	tli_ram #(.WIDTH(tli_pkg::CMD_W), .DEPTH(PROGRAM_WORDS)) u_prog (
		.clk   (clk),
		.we    (prog_we),
		.waddr (prog_waddr),
		.wdata (in_cmd),
		.raddr (prog_raddr),
		.rdata (prog_rdata)
	);

	tli_ram #(.WIDTH(8), .DEPTH(TAPE_CELLS)) u_tape (
		.clk   (clk),
		.we    (tape_we),
		.waddr (tape_waddr),
		.wdata (tape_wdata),
		.raddr (ptr_q),
		.rdata (tape_rdata)
	);

	tli_ram #(.WIDTH(PAW), .DEPTH(LOOP_DEPTH)) u_stack (
		.clk   (clk),
		.we    (stk_we),
		.waddr (depth_q[SAW-1:0]),
		.wdata (pc_q[PAW-1:0]),
		.raddr (stk_raddr),
		.rdata (stk_top)
	);

	always_comb begin
		state_d     = state_q;
		clr_d       = clr_q;
		reply_d     = reply_q;
		pc_d        = pc_q;
		ptr_d       = ptr_q;
		depth_d     = depth_q;
		halt_d      = halt_q;
		fault_d     = fault_q;
		scan_d      = scan_q;
		nest_d      = nest_q;
		prog_we     = 1'b0;
		prog_raddr  = pc_q[PAW-1:0];
		tape_we     = 1'b0;
		tape_waddr  = ptr_q;
		tape_wdata  = tape_rdata;
		stk_we      = 1'b0;
		fin         = 1'b0;
		r_out_valid = 1'b0;
		r_out_byte  = 8'd0;
		r_taken     = 1'b0;
		r_stalled   = 1'b0;

		case (state_q)
			ST_CLEAR: begin
				tape_we    = 1'b1;
				tape_waddr = clr_q;
				tape_wdata = 8'd0;
				clr_d      = clr_q + 1'b1;
				if (clr_q == TAPE_LAST) begin
					clr_d   = '0;
					state_d = reply_q ? ST_REPLY : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					state_d = ST_REPLY;
					case (in_op)
						tli_pkg::OP_LOAD: begin
							prog_we = addr_ok;
						end
						tli_pkg::OP_RESTART: begin
							pc_d    = '0;
							ptr_d   = TAPE_MID;
							depth_d = '0;
							halt_d  = 1'b0;
							fault_d = tli_pkg::FAULT_NONE;
							reply_d = 1'b1;
							state_d = ST_CLEAR;
						end
						tli_pkg::OP_STEP: begin
							if (!halt_q) begin
								if (pc_q >= len_w) begin
									halt_d = 1'b1;
								end else begin
									state_d = ST_EXEC;
								end
							end
						end
						default: begin
							state_d = ST_REPLY;
						end
					endcase
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					fin     = 1'b1;
					state_d = ST_IDLE;
					case (prog_rdata)
						tli_pkg::CMD_INC: begin
							tape_we    = 1'b1;
							tape_wdata = tape_rdata + 8'd1;
							pc_d       = pc_inc;
						end
						tli_pkg::CMD_DEC: begin
							tape_we    = 1'b1;
							tape_wdata = tape_rdata - 8'd1;
							pc_d       = pc_inc;
						end
						tli_pkg::CMD_RIGHT: begin
							ptr_d = (ptr_q == TAPE_LAST) ? '0 : ptr_q + 1'b1;
							pc_d  = pc_inc;
						end
						tli_pkg::CMD_LEFT: begin
							ptr_d = (ptr_q == '0) ? TAPE_LAST : ptr_q - 1'b1;
							pc_d  = pc_inc;
						end
						tli_pkg::CMD_OUT: begin
							r_out_valid = 1'b1;
							r_out_byte  = tape_rdata;
							pc_d        = pc_inc;
						end
						tli_pkg::CMD_IN: begin
							if (in_valid_q) begin
								tape_we    = 1'b1;
								tape_wdata = in_byte_q;
								r_taken    = 1'b1;
								pc_d       = pc_inc;
							end else begin
								r_stalled = 1'b1;
							end
						end
						tli_pkg::CMD_OPEN: begin
							if (tape_rdata != 8'd0) begin
								if (depth_q == STK_FULL) begin
									halt_d  = 1'b1;
									fault_d = tli_pkg::FAULT_OVERFLOW;
								end else begin
									stk_we  = 1'b1;
									depth_d = depth_q + 1'b1;
									pc_d    = pc_inc;
								end
							end else if (pc_inc >= len_w) begin
								halt_d  = 1'b1;
								fault_d = tli_pkg::FAULT_UNMATCHED;
							end else begin
								fin        = 1'b0;
								state_d    = ST_SCAN;
								scan_d     = pc_inc;
								nest_d     = NEST_ONE;
								prog_raddr = pc_inc[PAW-1:0];
							end
						end
						default: begin
							if (depth_q == '0) begin
								halt_d  = 1'b1;
								fault_d = tli_pkg::FAULT_UNMATCHED;
							end else if (tape_rdata != 8'd0) begin
								pc_d = PCW'(stk_top) + 1'b1;
							end else begin
								depth_d = depth_q - 1'b1;
								pc_d    = pc_inc;
							end
						end
					endcase
					if (pc_d >= len_w) begin
						halt_d = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				prog_raddr = scan_q[PAW-1:0];
				if (prog_rdata == tli_pkg::CMD_CLOSE && nest_q == NEST_ONE) begin
					if (out_free) begin
						fin     = 1'b1;
						state_d = ST_IDLE;
						pc_d    = scan_inc;
						if (scan_inc >= len_w) begin
							halt_d = 1'b1;
						end
					end
				end else if (scan_inc >= len_w) begin
					if (out_free) begin
						fin     = 1'b1;
						state_d = ST_IDLE;
						halt_d  = 1'b1;
						fault_d = tli_pkg::FAULT_UNMATCHED;
					end
				end else begin
					if (prog_rdata == tli_pkg::CMD_OPEN) begin
						nest_d = nest_q + 1'b1;
					end else if (prog_rdata == tli_pkg::CMD_CLOSE) begin
						nest_d = nest_q - 1'b1;
					end
					scan_d     = scan_inc;
					prog_raddr = scan_inc[PAW-1:0];
				end
			end
			ST_REPLY: begin
				if (out_free) begin
					fin     = 1'b1;
					reply_d = 1'b0;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			reply_q    <= 1'b0;
			pc_q       <= '0;
			ptr_q      <= TAPE_MID;
			depth_q    <= '0;
			halt_q     <= 1'b0;
			fault_q    <= tli_pkg::FAULT_NONE;
			len_cfg_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			clr_q   <= clr_d;
			reply_q <= reply_d;
			pc_q    <= pc_d;
			ptr_q   <= ptr_d;
			depth_q <= depth_d;
			halt_q  <= halt_d;
			fault_q <= fault_d;
			if (cfg_we) begin
				len_cfg_q <= cfg_wdata;
			end
			if (fin) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_q <= scan_d;
		nest_q <= nest_d;
		if (s_tvalid && s_tready) begin
			in_valid_q <= s_tuser[2];
			in_byte_q  <= s_tdata[22:15];
		end
		if (fin) begin
			m_tuser_q <= r_out_valid;
			m_tdata_q <= {3'b000, fault_d, halt_d, r_stalled, r_taken, r_out_byte};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// File: rtl/core/tli_checker.sv
// Port checker for the tape language interpreter core, bound to its top level.
// Depends on tli_pkg for the result word layout.
module tli_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [tli_pkg::M_TDATA_W-1:0] m_tdata,
	input logic                          m_tuser
);

	// A word that is taken leaves the core busy in the cycle after.
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
	else $error("core took a second word right after the first");

	// A fresh result only follows a cycle in which the core was busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> !$past(s_tready))
	else $error("result appeared without work in progress");

	// A stalled result word must stay put.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	else $error("result word changed while stalled");

	// A fault always comes with a halt.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[tli_pkg::M_FAULT_LSB +: tli_pkg::FAULT_W] != tli_pkg::FAULT_NONE)
		|-> m_tdata[tli_pkg::M_HALT_BIT])
	else $error("fault reported without halt");

endmodule

bind tape_language_interpreter_core tli_checker u_tli_checker (.*);
